// File: rtl/core/rsog_pkg.sv
package rsog_pkg;

    localparam int GRID_W     = 128;
    localparam int GRID_H     = 128;
    localparam int ANGLE_BITS = 16;

    localparam int STORE_CELLS = 16384;
    localparam int ADDR_W      = $clog2(STORE_CELLS);
    localparam int GRID_CELLS  = GRID_W * GRID_H;
    localparam int CORDIC_MAX  = 20;
    localparam int ITERS       = (ANGLE_BITS > CORDIC_MAX) ? CORDIC_MAX : ANGLE_BITS;
    localparam int CNT_W       = $clog2(CORDIC_MAX);

    // Datapath widths: x and y reach about range * 2^16, so 35 signed bits hold them.
    localparam int XW = 35;
    localparam int ZW = 34;
    localparam int PW = XW + 1;
    localparam int CW = 21;   // cell coordinate after the Q16 by Q16 scale
    localparam int COORD_W = 11;

    localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;
    localparam logic [31:0] ANG_MASK        = 32'hFFFF_FFFF << (32 - ANGLE_BITS);
    localparam logic [6:0]  COST_OCCUPIED   = 7'd100;

    localparam logic [31:0] ATAN_TAB [CORDIC_MAX] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304
    };

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_RAY   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [2:0] REG_RANGE_LOW  = 3'd0;
    localparam logic [2:0] REG_RANGE_HIGH = 3'd1;
    localparam logic [2:0] REG_START_ANG  = 3'd2;
    localparam logic [2:0] REG_ANG_STEP   = 3'd3;
    localparam logic [2:0] REG_SHIFT_X    = 3'd4;
    localparam logic [2:0] REG_SHIFT_Y    = 3'd5;
    localparam logic [2:0] REG_SCALE      = 3'd6;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ROT,
        S_SCALE,
        S_READ,
        S_RDATA,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] idx;
    } t_cell_res;

endpackage

// File: rtl/core/rsog_ram.sv
module rsog_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// File: rtl/core/rsog_cordic.sv
module rsog_cordic import rsog_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [15:0]          i_range,
    input  logic [15:0]          i_angle,
    output logic                 o_done,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y
);

    logic                 r_load, r_busy, r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [45:0]          r_prod;
    logic                 r_neg;
    logic signed [ZW-1:0] r_z;
    logic signed [XW-1:0] r_x, r_y;

    logic [31:0]          w_a;
    logic                 w_fold;
    logic [31:0]          w_af;
    logic signed [XW-1:0] w_x0, w_dx, w_dy;
    logic signed [ZW-1:0] w_at;

    always_comb begin
        w_a    = {i_angle, 16'd0} & ANG_MASK;
        w_fold = (w_a[31:30] == 2'd1) || (w_a[31:30] == 2'd2);
        w_af   = w_fold ? (w_a - 32'h8000_0000) : w_a;
        w_x0   = $signed({3'd0, r_prod[45:14]});
        w_dx   = r_y >>> r_cnt;
        w_dy   = r_x >>> r_cnt;
        w_at   = $signed({2'd0, ATAN_TAB[r_cnt]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= 1'b0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_load <= 1'b1;
            end else if (r_load) begin
                r_load <= 1'b0;
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // One micro-rotation per cycle; the sign of the residual angle picks the direction.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= i_range * CORDIC_GAIN_Q30;
            r_neg  <= w_fold;
            r_z    <= ZW'($signed(w_af));
        end else if (r_load) begin
            r_x <= r_neg ? -w_x0 : w_x0;
            r_y <= '0;
        end else if (r_busy) begin
            if (!r_z[ZW-1]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_at;
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;

endmodule

// File: rtl/core/rsog_cell.sv
module rsog_cell import rsog_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic [15:0]          i_shift_x,
    input  logic [15:0]          i_shift_y,
    input  logic [15:0]          i_scale,
    output logic                 o_done,
    output t_cell_res            o_res
);

    logic                 r_v1, r_v2;
    logic signed [CW-1:0] r_cx, r_cy;
    t_cell_res            r_res;

    logic signed [PW-1:0]    w_px, w_py;
    logic signed [PW+16:0]   w_mx, w_my;
    logic                    w_inx, w_iny;
    logic [2*COORD_W+1:0]    w_idx;

    always_comb begin
        w_px  = PW'(i_x) + PW'($signed({i_shift_x, 16'd0}));
        w_py  = PW'(i_y) + PW'($signed({i_shift_y, 16'd0}));
        w_mx  = w_px * $signed({1'b0, i_scale});
        w_my  = w_py * $signed({1'b0, i_scale});
        w_inx = !r_cx[CW-1] && (r_cx < CW'(GRID_W));
        w_iny = !r_cy[CW-1] && (r_cy < CW'(GRID_H));
        w_idx = (2*COORD_W+2)'(r_cy[COORD_W-1:0]) * (2*COORD_W+2)'(GRID_W)
              + (2*COORD_W+2)'(r_cx[COORD_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    // Taking the top bits of the product is the floor of the division by 2^32.
    always_ff @(posedge i_clk) begin
        r_cx      <= w_mx[PW+16:32];
        r_cy      <= w_my[PW+16:32];
        r_res.hit <= w_inx && w_iny && (w_idx < (2*COORD_W+2)'(STORE_CELLS));
        r_res.idx <= w_idx[ADDR_W-1:0];
    end

    assign o_done = r_v2;
    assign o_res  = r_res;

endmodule

// File: rtl/core/range_scan_to_occupancy_grid.sv
// Path from accept to result: a ray word in the window passes the rotate and scale states,
// a read word the two read states, a start word the clearing pass, any other word none.
// Throughput: one word at a time; the CORDIC loop, one micro-rotation a cycle, sets the
// ray rate. A finished result waits in the output register while the next word enters.
// Reset: synchronous, active low; registers take their reset values and a clearing pass
// writes all 16384 cells free before the first word is accepted.
module range_scan_to_occupancy_grid import rsog_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_range_mm,
    input  logic [13:0] i_cell_number,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_marked,
    output logic [13:0] o_hit_cell,
    output logic [6:0]  o_cost,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [15:0] r_low, r_high, r_start_ang, r_step, r_sx, r_sy, r_scale;
    logic [15:0] r_ray_angle;
    logic [ADDR_W-1:0] r_clr;
    logic        r_reply;
    logic [13:0] r_cell;
    logic        r_res_marked;
    logic [13:0] r_res_idx;
    logic [6:0]  r_res_cost;
    logic        r_out_v;
    logic        r_o_marked;
    logic [13:0] r_o_hit;
    logic [6:0]  r_o_cost;

    logic              w_accept, w_in_range, w_cell_ok, w_load_out;
    logic              w_we, w_wdata, w_cordic_start, w_cell_start;
    logic [ADDR_W-1:0] w_waddr;
    logic              w_rdata, w_cordic_done, w_cell_done;
    logic signed [XW-1:0] w_x, w_y;
    t_cell_res         w_cell_res;

    assign w_accept   = i_valid && o_ready;
    assign w_in_range = (i_range_mm >= r_low) && (i_range_mm <= r_high);
    assign w_cell_ok  = 32'(r_cell) < 32'(GRID_CELLS);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == ADDR_W'(STORE_CELLS - 1)) begin
                    n_state = r_reply ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_op)
                        OP_START: n_state = S_CLEAR;
                        OP_RAY:   n_state = w_in_range ? S_ROT : S_DONE;
                        OP_READ:  n_state = S_READ;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_ROT:   if (w_cordic_done) n_state = S_SCALE;
            S_SCALE: if (w_cell_done) n_state = S_DONE;
            S_READ:  n_state = S_RDATA;
            S_RDATA: n_state = S_DONE;
            S_DONE:  if (!r_out_v || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready        = 1'b0;
        w_we           = 1'b0;
        w_wdata        = 1'b0;
        w_waddr        = r_clr;
        w_cordic_start = 1'b0;
        w_cell_start   = 1'b0;
        w_load_out     = 1'b0;
        unique case (r_state)
            S_CLEAR: w_we = 1'b1;
            S_IDLE: begin
                o_ready        = 1'b1;
                w_cordic_start = i_valid && (i_op == OP_RAY) && w_in_range;
            end
            S_ROT: w_cell_start = w_cordic_done;
            S_SCALE: begin
                w_we    = w_cell_done && w_cell_res.hit;
                w_wdata = 1'b1;
                w_waddr = w_cell_res.idx;
            end
            S_DONE: w_load_out = !r_out_v || i_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_reply     <= 1'b0;
            r_out_v     <= 1'b0;
            r_ray_angle <= '0;
            r_low       <= 16'd0;
            r_high      <= 16'hFFFF;
            r_start_ang <= 16'd0;
            r_step      <= 16'd0;
            r_sx        <= 16'd200;
            r_sy        <= 16'd0;
            r_scale     <= 16'd655;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (w_load_out) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
            if (w_accept && (i_op == OP_START)) begin
                r_clr       <= '0;
                r_reply     <= 1'b1;
                r_ray_angle <= r_start_ang;
            end
            if (w_accept && (i_op == OP_RAY)) begin
                r_ray_angle <= r_ray_angle + r_step;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RANGE_LOW:  r_low       <= i_cfg_data;
                    REG_RANGE_HIGH: r_high      <= i_cfg_data;
                    REG_START_ANG:  r_start_ang <= i_cfg_data;
                    REG_ANG_STEP:   r_step      <= i_cfg_data;
                    REG_SHIFT_X:    r_sx        <= i_cfg_data;
                    REG_SHIFT_Y:    r_sy        <= i_cfg_data;
                    REG_SCALE:      r_scale     <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cell       <= i_cell_number;
            r_res_marked <= 1'b0;
            r_res_idx    <= '0;
            r_res_cost   <= '0;
        end
        if (r_state == S_SCALE && w_cell_done) begin
            r_res_marked <= w_cell_res.hit;
            r_res_idx    <= w_cell_res.hit ? w_cell_res.idx : '0;
        end
        if (r_state == S_RDATA) begin
            r_res_cost <= (w_cell_ok && w_rdata) ? COST_OCCUPIED : 7'd0;
        end
        if (w_load_out) begin
            r_o_marked <= r_res_marked;
            r_o_hit    <= r_res_idx;
            r_o_cost   <= r_res_cost;
        end
    end

    rsog_ram #(
        .WIDTH(1),
        .DEPTH(STORE_CELLS)
    ) u_grid (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_cell),
        .o_rdata(w_rdata)
    );

    rsog_cordic u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_cordic_start),
        .i_range(i_range_mm),
        .i_angle(r_ray_angle),
        .o_done (w_cordic_done),
        .o_x    (w_x),
        .o_y    (w_y)
    );

    rsog_cell u_cell (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_cell_start),
        .i_x      (w_x),
        .i_y      (w_y),
        .i_shift_x(r_sx),
        .i_shift_y(r_sy),
        .i_scale  (r_scale),
        .o_done   (w_cell_done),
        .o_res    (w_cell_res)
    );

    assign o_valid    = r_out_v;
    assign o_marked   = r_o_marked;
    assign o_hit_cell = r_o_hit;
    assign o_cost     = r_o_cost;

    a_clear_writes_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (w_we && !w_wdata))
        else $error("clearing pass wrote an occupied cell");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_op == OP_START)) |=> (r_state == S_CLEAR))
        else $error("start word did not begin a clearing pass");

    a_cordic_in_rot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cordic_done |-> (r_state == S_ROT))
        else $error("rotation finished outside the rotate state");

    a_marked_no_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_marked) |-> (o_cost == 7'd0))
        else $error("a ray word carried a cost");

endmodule
